// ===== rtl/fsc_pkg.sv =====
// Shared types and constants for the fan speed controller.
// Holds the register layout, the controller-to-datapath command and status
// structs and the fixed sizing constants. No dependencies.
package fsc_pkg;

    localparam int CHANNELS = 2;

    localparam logic [1:0] FAULT_LIMIT = 2'd3;
    localparam logic [6:0] AUX_HYST    = 7'd10;
    localparam logic [7:0] PWM_FULL    = 8'd255;
    localparam logic [7:0] EMA_ONE     = 8'd128;
    localparam logic       AUX_CH      = 1'b1;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        CFG_ALGO_MODE  = 3'd0,
        CFG_EMA_WEIGHT = 3'd1,
        CFG_PWM_FLOOR  = 3'd2,
        CFG_PWM_CEIL   = 3'd3,
        CFG_STOP_HYST  = 3'd4,
        CFG_LEVEL_LOW  = 3'd5,
        CFG_LEVEL_HIGH = 3'd6,
        CFG_PI_GAINS   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic       algo_mode;
        logic [7:0] ema_weight;
        logic [7:0] pwm_floor;
        logic [7:0] pwm_ceiling;
        logic [6:0] stop_hysteresis;
        logic [6:0] level_low;
        logic [6:0] level_high;
        logic [7:0] kp;
        logic [7:0] ki;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        algo_mode:       1'b0,
        ema_weight:      8'd64,
        pwm_floor:       8'd0,
        pwm_ceiling:     8'd255,
        stop_hysteresis: 7'd0,
        level_low:       7'd30,
        level_high:      7'd60,
        kp:              8'd0,
        ki:              8'd0
    };

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_FAULT  = 4'd2,
        OP_EMA_A  = 4'd3,
        OP_EMA_B  = 4'd4,
        OP_EMA_C  = 4'd5,
        OP_TP_CHK = 4'd6,
        OP_TP_MUL = 4'd7,
        OP_TP_FIN = 4'd8,
        OP_PI_KI  = 4'd9,
        OP_PI_INT = 4'd10,
        OP_PI_FIN = 4'd11
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic fault_full;
        logic tp_mid;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/fsc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Unsigned 16-bit dividend over 8-bit divisor; uses fsc_pkg.
module fsc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fsc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [7:0]                    rem_reg;
    logic [7:0]                    dsr_reg;
    logic [15:0]                   quo_reg;

    logic [8:0] trial;
    logic       fits;
    logic [7:0] rem_next;

    assign trial    = {rem_reg, quo_reg[15]};
    assign fits     = (trial >= {1'b0, dsr_reg});
    assign rem_next = fits ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= fsc_pkg::DIV_CNT_W'(fsc_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[14:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> divisor != '0)
        else $error("divider started with zero divisor");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

// ===== rtl/fsc_cfg.sv =====
// Configuration register file shared by all fan channels.
// Register layout and reset values come from fsc_pkg.
module fsc_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output fsc_pkg::cfg_t cfg
);

    fsc_pkg::cfg_t cfg_reg;
    fsc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (fsc_pkg::cfg_idx_t'(cfg_index))
                fsc_pkg::CFG_ALGO_MODE:  cfg_next.algo_mode       = cfg_data[0];
                fsc_pkg::CFG_EMA_WEIGHT: cfg_next.ema_weight      = cfg_data[7:0];
                fsc_pkg::CFG_PWM_FLOOR:  cfg_next.pwm_floor       = cfg_data[7:0];
                fsc_pkg::CFG_PWM_CEIL:   cfg_next.pwm_ceiling     = cfg_data[7:0];
                fsc_pkg::CFG_STOP_HYST:  cfg_next.stop_hysteresis = cfg_data[6:0];
                fsc_pkg::CFG_LEVEL_LOW:  cfg_next.level_low       = cfg_data[6:0];
                fsc_pkg::CFG_LEVEL_HIGH: cfg_next.level_high      = cfg_data[6:0];
                fsc_pkg::CFG_PI_GAINS:
                begin
                    cfg_next.kp = cfg_data[15:8];
                    cfg_next.ki = cfg_data[7:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= fsc_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

// ===== rtl/fsc_dp.sv =====
// Datapath: per-channel state, shared multiplier, EMA, two-point and PI math.
// Driven by fsc_ctrl commands; uses fsc_pkg and instantiates fsc_div.
module fsc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  fsc_pkg::cfg_t     cfg,
    input  fsc_pkg::dp_cmd_t  cmd,
    output fsc_pkg::dp_stat_t stat,
    input  logic              channel,
    input  logic [15:0]       temperature,
    input  logic              sensor_fault,
    output logic [7:0]        pwm_duty,
    output logic              fan_stopped,
    output logic              aux_fan_on
);

    // per-channel state, plus the single aux fan flag
    logic signed [15:0] ema_prev_reg [fsc_pkg::CHANNELS];
    logic [14:0]        integ_reg    [fsc_pkg::CHANNELS];
    logic [1:0]         fcnt_reg     [fsc_pkg::CHANNELS];
    logic               stop_reg     [fsc_pkg::CHANNELS];
    logic               aux_reg;

    // item registers
    logic               ch_reg;
    logic signed [15:0] x_reg;
    logic               fault_reg;
    logic signed [15:0] cur_reg;
    logic signed [24:0] prod_reg;
    logic signed [24:0] acc_reg;
    logic [14:0]        isum_reg;
    logic [7:0]         res_duty_reg;
    logic               res_stop_reg;
    logic               res_aux_reg;
    logic [7:0]         duty_out_reg;
    logic               stop_out_reg;
    logic               aux_out_reg;

    logic [7:0]  w;
    logic [7:0]  wc;
    logic [7:0]  lo2;
    logic [7:0]  hi2;
    logic signed [17:0] cur_x;
    logic signed [17:0] lo2_x;
    logic signed [17:0] hi2_x;
    logic signed [17:0] hy2_x;
    logic signed [17:0] neg_hy2;
    logic signed [17:0] aux_hyst_x;
    logic signed [17:0] lo_gap;
    logic signed [17:0] hi_gap;
    logic signed [17:0] err_full;
    logic signed [15:0] err;
    logic signed [17:0] err_x;
    logic        ge_hi;
    logic        le_lo;
    logic        mid;
    logic        hyst_on;
    logic [7:0]  trange;
    logic [7:0]  span;
    logic [7:0]  tn;
    logic        div_done;
    logic [15:0] quotient;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_p;

    logic signed [24:0] ema_sum;
    logic signed [15:0] ema_new;
    logic signed [25:0] isum_x;
    logic signed [25:0] imax_x;
    logic [14:0]        isum_clamp;
    logic [18:0]        pi_p;
    logic [19:0]        pi_pf;
    logic [8:0]         idle_duty;

    logic        stop_cur;
    logic [1:0]  fcnt_cur;
    logic        fault_full;
    logic [7:0]  tp_duty;
    logic        tp_stop;
    logic        tp_aux;
    logic [7:0]  pi_duty;
    logic        pi_stop;

    assign stop_cur   = stop_reg[ch_reg];
    assign fcnt_cur   = fcnt_reg[ch_reg];
    assign fault_full = fault_reg && (fcnt_cur == fsc_pkg::FAULT_LIMIT);

    assign w  = (cfg.ema_weight > fsc_pkg::EMA_ONE) ? fsc_pkg::EMA_ONE : cfg.ema_weight;
    assign wc = fsc_pkg::EMA_ONE - w;

    assign lo2        = {cfg.level_low, 1'b0};
    assign hi2        = {cfg.level_high, 1'b0};
    assign cur_x      = {{2{cur_reg[15]}}, cur_reg};
    assign lo2_x      = {10'b0, lo2};
    assign hi2_x      = {10'b0, hi2};
    assign hy2_x      = {10'b0, cfg.stop_hysteresis, 1'b0};
    assign neg_hy2    = 18'sd0 - hy2_x;
    assign aux_hyst_x = {11'b0, fsc_pkg::AUX_HYST};
    assign lo_gap     = lo2_x - cur_x;
    assign hi_gap     = hi2_x - cur_x;
    assign ge_hi      = (cur_x >= hi2_x);
    assign le_lo      = (cur_x <= lo2_x);
    assign mid        = !ge_hi && !le_lo;
    assign hyst_on    = (cfg.stop_hysteresis != '0);

    // saturate low side only; the top cannot overflow
    assign err_full = cur_x - lo2_x;
    assign err      = (err_full < -18'sd32768) ? 16'sh8000 : err_full[15:0];
    assign err_x    = {{2{err[15]}}, err};

    assign trange = hi2 - lo2;
    assign span   = (cfg.pwm_ceiling >= cfg.pwm_floor) ?
                    8'(cfg.pwm_ceiling - cfg.pwm_floor) : 8'd0;
    assign tn     = cur_reg[7:0] - lo2;

    fsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((cmd.op == fsc_pkg::OP_TP_CHK) && mid),
        .dividend ({span, 8'h00}),
        .divisor  (trange),
        .done     (div_done),
        .quotient (quotient)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            fsc_pkg::OP_EMA_A:
            begin
                mul_a = {9'b0, w};
                mul_b = {x_reg[15], x_reg};
            end
            fsc_pkg::OP_EMA_B:
            begin
                mul_a = {9'b0, wc};
                mul_b = {ema_prev_reg[ch_reg][15], ema_prev_reg[ch_reg]};
            end
            fsc_pkg::OP_TP_MUL:
            begin
                mul_a = {1'b0, quotient};
                mul_b = {9'b0, tn};
            end
            fsc_pkg::OP_PI_KI:
            begin
                mul_a = {9'b0, cfg.ki};
                mul_b = {err[15], err};
            end
            fsc_pkg::OP_PI_INT:
            begin
                mul_a = {9'b0, cfg.kp};
                mul_b = {err[15], err};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign ema_sum = acc_reg + prod_reg;
    assign ema_new = ema_sum[22:7];

    // integral update, clamped to 0..level_high*256
    assign isum_x = {11'b0, integ_reg[ch_reg]} + {prod_reg[24], prod_reg};
    assign imax_x = {11'b0, cfg.level_high, 8'b0};
    always_comb
    begin
        priority if (isum_x > imax_x)
            isum_clamp = imax_x[14:0];
        else if (isum_x[25])
            isum_clamp = '0;
        else
            isum_clamp = isum_x[14:0];
    end

    assign pi_p      = {1'b0, prod_reg[22:5]} + {12'b0, isum_reg[14:8]};
    assign pi_pf     = {1'b0, pi_p} + {12'b0, cfg.pwm_floor};
    assign idle_duty = {1'b0, cfg.pwm_floor} + {2'b0, isum_reg[14:8]};

    always_comb
    begin
        tp_duty = '0;
        tp_stop = stop_cur;
        priority if (ge_hi)
            tp_duty = cfg.pwm_ceiling;
        else if (le_lo)
        begin
            if (hyst_on && (lo_gap > hy2_x))
                tp_stop = 1'b1;
            else if (!stop_cur)
                tp_duty = cfg.pwm_floor;
        end
        else
        begin
            tp_duty = prod_reg[15:8] + cfg.pwm_floor;
            tp_stop = 1'b0;
        end

        tp_aux = aux_reg;
        if (ch_reg == fsc_pkg::AUX_CH)
        begin
            priority if (ge_hi)
                tp_aux = 1'b1;
            else if (hi_gap >= aux_hyst_x)
                tp_aux = 1'b0;
            else
                tp_aux = aux_reg;
        end
    end

    always_comb
    begin
        pi_duty = '0;
        pi_stop = stop_cur;
        priority if (err > 16'sd0)
        begin
            pi_duty = (pi_pf < {12'b0, cfg.pwm_ceiling}) ? pi_pf[7:0] : cfg.pwm_ceiling;
            pi_stop = 1'b0;
        end
        else if (hyst_on && (err_x < neg_hy2))
            pi_stop = 1'b1;
        else if (!stop_cur)
            pi_duty = idle_duty[8] ? 8'hFF : idle_duty[7:0];
        else
            pi_duty = '0;
    end

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsc_pkg::CHANNELS; i++)
            begin
                ema_prev_reg[i] <= '0;
                integ_reg[i]    <= '0;
                fcnt_reg[i]     <= '0;
                stop_reg[i]     <= 1'b0;
            end
            aux_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                fsc_pkg::OP_FAULT:
                begin
                    if (!fault_reg)
                        fcnt_reg[ch_reg] <= '0;
                    else if (!fault_full)
                        fcnt_reg[ch_reg] <= fcnt_cur + 1'b1;
                end
                fsc_pkg::OP_EMA_C:
                    ema_prev_reg[ch_reg] <= ema_new;
                fsc_pkg::OP_TP_FIN:
                begin
                    stop_reg[ch_reg] <= tp_stop;
                    aux_reg          <= tp_aux;
                end
                fsc_pkg::OP_PI_INT:
                    integ_reg[ch_reg] <= isum_clamp;
                fsc_pkg::OP_PI_FIN:
                    stop_reg[ch_reg] <= pi_stop;
                default:
                begin
                end
            endcase
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            fsc_pkg::OP_LOAD:
            begin
                ch_reg    <= channel;
                x_reg     <= temperature;
                fault_reg <= sensor_fault;
            end
            fsc_pkg::OP_FAULT:
            begin
                if (fault_full)
                begin
                    res_duty_reg <= fsc_pkg::PWM_FULL;
                    res_stop_reg <= stop_cur;
                    res_aux_reg  <= aux_reg;
                end
                else if (fault_reg)
                    x_reg <= ema_prev_reg[ch_reg];
            end
            fsc_pkg::OP_EMA_A:
                prod_reg <= mul_p[24:0];
            fsc_pkg::OP_EMA_B:
            begin
                acc_reg  <= prod_reg + 25'sd64;
                prod_reg <= mul_p[24:0];
            end
            fsc_pkg::OP_EMA_C:
                cur_reg <= ema_new;
            fsc_pkg::OP_TP_MUL:
                prod_reg <= mul_p[24:0];
            fsc_pkg::OP_TP_FIN:
            begin
                res_duty_reg <= tp_duty;
                res_stop_reg <= tp_stop;
                res_aux_reg  <= tp_aux;
            end
            fsc_pkg::OP_PI_KI:
                prod_reg <= mul_p[24:0];
            fsc_pkg::OP_PI_INT:
            begin
                isum_reg <= isum_clamp;
                prod_reg <= mul_p[24:0];
            end
            fsc_pkg::OP_PI_FIN:
            begin
                res_duty_reg <= pi_duty;
                res_stop_reg <= pi_stop;
                res_aux_reg  <= aux_reg;
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            duty_out_reg <= res_duty_reg;
            stop_out_reg <= res_stop_reg;
            aux_out_reg  <= res_aux_reg;
        end
    end

    assign stat.fault_full = fault_full;
    assign stat.tp_mid     = mid;
    assign stat.div_done   = div_done;

    assign pwm_duty    = duty_out_reg;
    assign fan_stopped = stop_out_reg;
    assign aux_fan_on  = aux_out_reg;

endmodule

// ===== rtl/fsc_ctrl.sv =====
// Controller state machine: sequences one update through the datapath and
// owns both handshakes. Uses fsc_pkg command and status structs.
module fsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              algo_mode,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  fsc_pkg::dp_stat_t stat,
    output fsc_pkg::dp_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_FAULT  = 13'b0000000000010,
        S_EMA_A  = 13'b0000000000100,
        S_EMA_B  = 13'b0000000001000,
        S_EMA_C  = 13'b0000000010000,
        S_TP_CHK = 13'b0000000100000,
        S_TP_DIV = 13'b0000001000000,
        S_TP_MUL = 13'b0000010000000,
        S_TP_FIN = 13'b0000100000000,
        S_PI_KI  = 13'b0001000000000,
        S_PI_INT = 13'b0010000000000,
        S_PI_FIN = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = fsc_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = fsc_pkg::OP_LOAD;
                    state_next = S_FAULT;
                end
            end
            S_FAULT:
            begin
                cmd.op     = fsc_pkg::OP_FAULT;
                state_next = stat.fault_full ? S_DONE : S_EMA_A;
            end
            S_EMA_A:
            begin
                cmd.op     = fsc_pkg::OP_EMA_A;
                state_next = S_EMA_B;
            end
            S_EMA_B:
            begin
                cmd.op     = fsc_pkg::OP_EMA_B;
                state_next = S_EMA_C;
            end
            S_EMA_C:
            begin
                cmd.op     = fsc_pkg::OP_EMA_C;
                state_next = algo_mode ? S_PI_KI : S_TP_CHK;
            end
            S_TP_CHK:
            begin
                cmd.op     = fsc_pkg::OP_TP_CHK;
                state_next = stat.tp_mid ? S_TP_DIV : S_TP_FIN;
            end
            S_TP_DIV:
            begin
                if (stat.div_done)
                    state_next = S_TP_MUL;
            end
            S_TP_MUL:
            begin
                cmd.op     = fsc_pkg::OP_TP_MUL;
                state_next = S_TP_FIN;
            end
            S_TP_FIN:
            begin
                cmd.op     = fsc_pkg::OP_TP_FIN;
                state_next = S_DONE;
            end
            S_PI_KI:
            begin
                cmd.op     = fsc_pkg::OP_PI_KI;
                state_next = S_PI_INT;
            end
            S_PI_INT:
            begin
                cmd.op     = fsc_pkg::OP_PI_INT;
                state_next = S_PI_FIN;
            end
            S_PI_FIN:
            begin
                cmd.op     = fsc_pkg::OP_PI_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled beat");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in progress");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_TP_DIV)
        else $error("divider finished outside its wait state");

endmodule

// ===== rtl/fan_speed_controller.sv =====
// Fan speed controller top level: config registers, controller and datapath.
// Depends on fsc_pkg, fsc_cfg, fsc_ctrl, fsc_dp (and fsc_div below it).
//
// One update is handled at a time. After an input beat is taken, in_stall
// stays high until the result has moved into the output register. The next
// item can be taken the cycle after that, while the previous result may still
// wait on out_stall. A channel whose sensor fault has reached the limit goes
// straight to a full-drive result; other updates run the EMA steps, then the
// two-point or PI steps, and a two-point update inside the low..high band also
// waits on the serial divider that forms the interpolation slope. One multiplier
// is shared by the EMA, two-point and PI steps. Configuration writes are taken in
// any cycle (cfg_ready is always high) but are meant for idle periods.
module fan_speed_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        channel,
    input  logic [15:0] temperature,
    input  logic        sensor_fault,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pwm_duty,
    output logic        fan_stopped,
    output logic        aux_fan_on,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fsc_pkg::cfg_t     cfg;
    fsc_pkg::dp_cmd_t  cmd;
    fsc_pkg::dp_stat_t stat;

    fsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .algo_mode (cfg.algo_mode),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fsc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .channel      (channel),
        .temperature  (temperature),
        .sensor_fault (sensor_fault),
        .pwm_duty     (pwm_duty),
        .fan_stopped  (fan_stopped),
        .aux_fan_on   (aux_fan_on)
    );

endmodule

// ===== tb/tb_fan_speed_controller.sv =====
// Self-checking testbench for fan_speed_controller: random and directed updates
// checked against an in-bench model of the EMA, two-point and PI fan control.
// Depends on fsc_pkg and the fan_speed_controller RTL.
module tb_fan_speed_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 82;

    typedef struct packed {
        logic        ch;
        logic [15:0] temp;
        logic        fault;
    } fan_update_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       stopped;
        logic       aux;
    } fan_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        channel = 1'b0;
    logic [15:0] temperature = '0;
    logic        sensor_fault = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  pwm_duty;
    logic        fan_stopped;
    logic        aux_fan_on;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // model state, per channel except the settings and the single aux flag
    fsc_pkg::cfg_t ctl_cfg = fsc_pkg::CFG_RESET;
    int          avg_temp [fsc_pkg::CHANNELS];
    int          integ_acc [fsc_pkg::CHANNELS];
    logic [1:0]  fault_run [fsc_pkg::CHANNELS];
    logic        fan_off [fsc_pkg::CHANNELS];
    logic        aux_on;

    fan_update_t update_queue [$];
    fan_result_t duty_expected [$];

    int n_queued = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_forced = 0;
    int n_stopped = 0;
    int n_aux = 0;
    int n_cfg_writes = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_recv = 1'b0;
    logic pressure_go = 1'b0;

    fan_speed_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .temperature  (temperature),
        .sensor_fault (sensor_fault),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pwm_duty     (pwm_duty),
        .fan_stopped  (fan_stopped),
        .aux_fan_on   (aux_fan_on),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < fsc_pkg::CHANNELS; i++)
        begin
            avg_temp[i] = 0;
            integ_acc[i] = 0;
            fault_run[i] = '0;
            fan_off[i] = 1'b0;
        end
        aux_on = 1'b0;
    end

    function automatic fan_result_t compute_fan_duty(logic ch, logic [15:0] raw, logic fault);
        int          cur, w, acc, lo2, hi2, hy2, err, kp, ki, imax, sum;
        int unsigned span, slope, tn, p, duty;
        fan_result_t res;
        cur = int'($signed(raw));
        duty = 0;
        if (fault)
        begin
            if (fault_run[ch] != fsc_pkg::FAULT_LIMIT)
            begin
                fault_run[ch] = fault_run[ch] + 2'd1;
                cur = avg_temp[ch];
            end
            else
            begin
                // persistent fault: full drive, state untouched
                n_forced++;
                res.duty = fsc_pkg::PWM_FULL;
                res.stopped = fan_off[ch];
                res.aux = aux_on;
                return res;
            end
        end
        else
            fault_run[ch] = '0;

        w = (int'(ctl_cfg.ema_weight) > 128) ? 128 : int'(ctl_cfg.ema_weight);
        acc = w * cur + (128 - w) * avg_temp[ch] + 64 + (1 << 23);
        cur = (acc >>> 7) - 65536;
        avg_temp[ch] = cur;

        lo2 = int'(ctl_cfg.level_low) * 2;
        hi2 = int'(ctl_cfg.level_high) * 2;
        hy2 = int'(ctl_cfg.stop_hysteresis) * 2;
        if (!ctl_cfg.algo_mode)
        begin
            if (cur >= hi2)
                duty = ctl_cfg.pwm_ceiling;
            else if (cur <= lo2)
            begin
                if (ctl_cfg.stop_hysteresis != 0 && (lo2 - cur) > hy2)
                    fan_off[ch] = 1'b1;
                else if (!fan_off[ch])
                    duty = ctl_cfg.pwm_floor;
            end
            else
            begin
                span = (ctl_cfg.pwm_ceiling >= ctl_cfg.pwm_floor) ?
                       int'(ctl_cfg.pwm_ceiling) - int'(ctl_cfg.pwm_floor) : 0;
                slope = (span << 8) / int'(hi2 - lo2);
                tn = cur - lo2;
                duty = ((slope * tn) >> 8) + ctl_cfg.pwm_floor;
                fan_off[ch] = 1'b0;
            end
            if (ch == fsc_pkg::AUX_CH)
            begin
                if (cur >= hi2)
                    aux_on = 1'b1;
                else if (hi2 - cur >= int'(fsc_pkg::AUX_HYST))
                    aux_on = 1'b0;
            end
        end
        else
        begin
            err = cur - lo2;
            if (err > 32767)
                err = 32767;
            if (err < -32768)
                err = -32768;
            kp = int'(ctl_cfg.kp);
            ki = int'(ctl_cfg.ki);
            imax = int'(ctl_cfg.level_high) * 256;
            sum = integ_acc[ch] + ki * err;
            if (sum > imax)
                sum = imax;
            else if (sum < 0)
                sum = 0;
            integ_acc[ch] = sum;
            if (err > 0)
            begin
                p = (unsigned'(kp * err) >> 5) + (unsigned'(sum) >> 8);
                if (p + ctl_cfg.pwm_floor < ctl_cfg.pwm_ceiling)
                    duty = p + ctl_cfg.pwm_floor;
                else
                    duty = ctl_cfg.pwm_ceiling;
                fan_off[ch] = 1'b0;
            end
            else if (ctl_cfg.stop_hysteresis != 0 && err < -hy2)
                fan_off[ch] = 1'b1;
            else if (!fan_off[ch])
            begin
                duty = ctl_cfg.pwm_floor + (unsigned'(sum) >> 8);
                if (duty > 255)
                    duty = 255;
            end
        end
        res.duty = duty[7:0];
        res.stopped = fan_off[ch];
        res.aux = aux_on;
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        n_errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_results, field, got, want);
    endtask

    // driver: present the next pending update, hold it while stalled
    always @(posedge clk)
    begin
        fan_update_t beat;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                duty_expected.push_back(compute_fan_duty(channel, temperature, sensor_fault));
            if (!in_valid || !in_stall)
            begin
                if (update_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat = update_queue.pop_front();
                    channel <= beat.ch;
                    temperature <= beat.temp;
                    sensor_fault <= beat.fault;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        fan_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (duty_expected.size() == 0)
                    report_mismatch("unexpected beat, pwm_duty", pwm_duty, -1);
                else
                begin
                    want = duty_expected.pop_front();
                    if (pwm_duty !== want.duty)
                        report_mismatch("pwm_duty", pwm_duty, want.duty);
                    if (fan_stopped !== want.stopped)
                        report_mismatch("fan_stopped", fan_stopped, want.stopped);
                    if (aux_fan_on !== want.aux)
                        report_mismatch("aux_fan_on", aux_fan_on, want.aux);
                end
                if (fan_stopped)
                    n_stopped++;
                if (aux_fan_on)
                    n_aux++;
            end
            out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_fan_speed_controller: FAIL");
            $finish;
        end
    end

    // long receiver hold so the block backs up into its input
    initial
    begin
        wait (pressure_go);
        repeat (20) @(posedge clk);
        hold_recv <= 1'b1;
        repeat (300) @(posedge clk);
        hold_recv <= 1'b0;
    end

    task automatic write_reg(fsc_pkg::cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        n_cfg_writes++;
        case (idx)
            fsc_pkg::CFG_ALGO_MODE:  ctl_cfg.algo_mode = value[0];
            fsc_pkg::CFG_EMA_WEIGHT: ctl_cfg.ema_weight = value[7:0];
            fsc_pkg::CFG_PWM_FLOOR:  ctl_cfg.pwm_floor = value[7:0];
            fsc_pkg::CFG_PWM_CEIL:   ctl_cfg.pwm_ceiling = value[7:0];
            fsc_pkg::CFG_STOP_HYST:  ctl_cfg.stop_hysteresis = value[6:0];
            fsc_pkg::CFG_LEVEL_LOW:  ctl_cfg.level_low = value[6:0];
            fsc_pkg::CFG_LEVEL_HIGH: ctl_cfg.level_high = value[6:0];
            fsc_pkg::CFG_PI_GAINS:
            begin
                ctl_cfg.kp = value[15:8];
                ctl_cfg.ki = value[7:0];
            end
            default: ;
        endcase
    endtask

    // call only right after the clock rises, with the block idle
    task automatic write_settings(fsc_pkg::cfg_t s);
        write_reg(fsc_pkg::CFG_ALGO_MODE, {15'd0, s.algo_mode});
        write_reg(fsc_pkg::CFG_EMA_WEIGHT, {8'd0, s.ema_weight});
        write_reg(fsc_pkg::CFG_PWM_FLOOR, {8'd0, s.pwm_floor});
        write_reg(fsc_pkg::CFG_PWM_CEIL, {8'd0, s.pwm_ceiling});
        write_reg(fsc_pkg::CFG_STOP_HYST, {9'd0, s.stop_hysteresis});
        write_reg(fsc_pkg::CFG_LEVEL_LOW, {9'd0, s.level_low});
        write_reg(fsc_pkg::CFG_LEVEL_HIGH, {9'd0, s.level_high});
        write_reg(fsc_pkg::CFG_PI_GAINS, {s.kp, s.ki});
        cfg_valid <= 1'b0;
    endtask

    task automatic push_update(logic ch, int temp, logic fault);
        fan_update_t u;
        if (temp > 32767)
            temp = 32767;
        if (temp < -32767)
            temp = -32767;
        u.ch = ch;
        u.temp = temp[15:0];
        u.fault = fault;
        update_queue.push_back(u);
        n_queued++;
    endtask

    function automatic int pick_temp();
        int lo2, hi2, lo_b, hi_b, r;
        lo2 = int'(ctl_cfg.level_low) * 2;
        hi2 = int'(ctl_cfg.level_high) * 2;
        r = $urandom_range(99);
        if (r < 12)
            return int'($urandom_range(65534)) - 32767;
        if (r < 18)
            return (r < 15) ? 32767 : -32767;
        // mostly near the control band, reaching below it past the stop margin
        lo_b = ((lo2 < hi2) ? lo2 : hi2) - 4 * int'(ctl_cfg.stop_hysteresis) - 30;
        hi_b = ((lo2 > hi2) ? lo2 : hi2) + 40;
        return lo_b + int'($urandom_range(hi_b - lo_b));
    endfunction

    task automatic drain_updates();
        while (n_results < n_queued)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        fsc_pkg::cfg_t s;
        int   n, len;
        logic ch;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_stall_pct = 87;

        // reset settings: extremes, aux on and off, fault run up to the limit
        push_update(1'b0, 32767, 1'b0);
        push_update(1'b0, -32767, 1'b0);
        push_update(1'b1, 32767, 1'b0);
        push_update(1'b1, 32767, 1'b0);
        push_update(1'b1, 100, 1'b0);
        push_update(1'b1, -32767, 1'b0);
        repeat (5) push_update(1'b0, 0, 1'b1);
        push_update(1'b0, 90, 1'b0);
        drain_updates();

        // exact tracking: floor, stop, held stop, resume, ceiling, aux band
        s = fsc_pkg::CFG_RESET;
        s.ema_weight = 8'd128;
        s.pwm_floor = 8'd40;
        s.pwm_ceiling = 8'd200;
        s.stop_hysteresis = 7'd5;
        s.kp = 8'h12;
        s.ki = 8'h34;
        write_settings(s);
        push_update(1'b0, 60, 1'b0);
        push_update(1'b0, 49, 1'b0);
        push_update(1'b0, 55, 1'b0);
        push_update(1'b0, 61, 1'b0);
        push_update(1'b0, 120, 1'b0);
        push_update(1'b1, 120, 1'b0);
        push_update(1'b1, 115, 1'b0);
        push_update(1'b1, 110, 1'b0);
        push_update(1'b0, 32767, 1'b0);
        push_update(1'b0, -32767, 1'b0);
        drain_updates();

        for (int p = 0; p < 10; p++)
        begin
            s.algo_mode = p[0];
            s.ema_weight = ($urandom_range(1) != 0) ? 8'd128 : 8'($urandom_range(255));
            s.pwm_floor = 8'($urandom_range(80));
            s.pwm_ceiling = 8'($urandom_range(255, 150));
            s.stop_hysteresis = 7'($urandom_range(12));
            s.level_low = 7'($urandom_range(60, 10));
            s.level_high = s.level_low + 7'($urandom_range(40, 1));
            s.kp = 8'($urandom_range(255));
            s.ki = 8'($urandom_range(255));
            case (p)
                1:
                begin
                    s.ema_weight = 8'd0;
                    s.kp = 8'hFF;
                    s.ki = 8'hFF;
                end
                2:
                begin
                    s.pwm_floor = 8'd200;
                    s.pwm_ceiling = 8'd20;
                end
                3:
                begin
                    s.stop_hysteresis = 7'd127;
                    s.level_low = 7'd127;
                    s.level_high = 7'd0;
                    s.kp = 8'hFF;
                    s.ki = 8'hFF;
                end
                4:
                begin
                    s.ema_weight = 8'd255;
                    s.level_low = 7'd0;
                    s.level_high = 7'd127;
                    s.pwm_floor = 8'd0;
                    s.pwm_ceiling = 8'd255;
                    s.stop_hysteresis = 7'd0;
                end
                5:
                begin
                    s.pwm_floor = 8'd255;
                    s.pwm_ceiling = 8'd255;
                    s.kp = 8'd0;
                    s.ki = 8'd0;
                end
                6:
                begin
                    s.level_low = 7'd127;
                    s.level_high = 7'd127;
                end
                7:
                begin
                    s.stop_hysteresis = 7'd127;
                    s.level_low = 7'd0;
                    s.level_high = 7'd127;
                    s.pwm_floor = 8'd255;
                    s.pwm_ceiling = 8'd0;
                end
                8:
                begin
                    s.level_low = 7'd0;
                    s.level_high = 7'd0;
                end
                default: ;
            endcase
            if (p < 4)
            begin
                send_idle_pct = 20;
                recv_stall_pct = 87;
            end
            else if (p < 7)
            begin
                send_idle_pct = 87;
                recv_stall_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_settings(s);
            if (p == 9)
                pressure_go = 1'b1;

            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 8)
                begin
                    // fault run on one channel, then a clean reading
                    ch = 1'($urandom_range(1));
                    len = $urandom_range(5, 1);
                    repeat (len) push_update(ch, pick_temp(), 1'b1);
                    push_update(ch, pick_temp(), 1'b0);
                    n += len + 1;
                end
                else
                begin
                    push_update(1'($urandom_range(1)), pick_temp(), $urandom_range(99) < 5);
                    n++;
                end
            end
            drain_updates();
        end

        if (duty_expected.size() != 0)
            report_mismatch("results never seen", 0, duty_expected.size());
        $display("ran %0d updates over 12 register settings with %0d register writes",
                 n_queued, n_cfg_writes);
        $display("saw %0d fault-forced, %0d stopped and %0d aux-on results",
                 n_forced, n_stopped, n_aux);
        if (n_errors == 0)
            $display("tb_fan_speed_controller: PASS");
        else
            $display("tb_fan_speed_controller: FAIL");
        $finish;
    end

endmodule
